// ----- rtl/arbp_pkg.sv -----
// ----------------------------------------------------------------------------
// arbp_pkg
// Types, codes and lookup functions shared by the alignment record parser.
// ----------------------------------------------------------------------------
package arbp_pkg;

  typedef enum logic [2:0] {
    SEC_HEADER = 3'd0,
    SEC_NAME   = 3'd1,
    SEC_CIGAR  = 3'd2,
    SEC_SEQ    = 3'd3,
    SEC_QUAL   = 3'd4,
    SEC_TAIL   = 3'd5
  } section_e;

  typedef enum logic [2:0] {
    KIND_REF  = 3'd0,
    KIND_POS  = 3'd1,
    KIND_NAME = 3'd2,
    KIND_OP   = 3'd3,
    KIND_BASE = 3'd4,
    KIND_QUAL = 3'd5,
    KIND_ERR  = 3'd6
  } kind_e;

  // Header byte offsets that carry fields
  localparam logic [8:0] OFS_REF_ID   = 9'd3;
  localparam logic [8:0] OFS_POS      = 9'd7;
  localparam logic [8:0] OFS_NAME_LEN = 9'd8;
  localparam logic [8:0] OFS_CIGAR_N  = 9'd13;
  localparam logic [8:0] OFS_SEQ_LEN  = 9'd19;
  localparam logic [8:0] OFS_HDR_LAST = 9'd31;
  localparam logic [8:0] HEADER_BYTES = 9'd32;

  localparam logic [3:0] OP_MAX     = 4'd8;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  typedef struct packed {
    logic [8:0]  offset;     // saturating byte offset, only compared in header/name
    logic [31:0] word;       // little-endian assembly, or held name char
    logic [7:0]  name_len;
    logic [15:0] cigar_cnt;
    logic [31:0] seq_len;
    logic [31:0] left;       // bases or qualities still to come
    logic [1:0]  phase;      // byte position inside a CIGAR word
    section_e    section;
    logic        failed;
  } arbp_state_t;

  localparam arbp_state_t ST_RESET = '{
    offset:    '0,
    word:      '0,
    name_len:  '0,
    cigar_cnt: '0,
    seq_len:   '0,
    left:      '0,
    phase:     '0,
    section:   SEC_HEADER,
    failed:    1'b0
  };

  typedef struct packed {
    kind_e       item_kind;
    logic [7:0]  symbol;
    logic [31:0] value;
    logic        record_done;
  } res_t;

  function automatic res_t mk_res(kind_e k, logic [7:0] s, logic [31:0] v, logic d);
    res_t r;
    r.item_kind   = k;
    r.symbol      = s;
    r.value       = v;
    r.record_done = d;
    return r;
  endfunction

  function automatic logic [7:0] op_letter(logic [3:0] op);
    logic [7:0] c;
    case (op)
      4'd0:    c = "M";
      4'd1:    c = "I";
      4'd2:    c = "D";
      4'd3:    c = "N";
      4'd4:    c = "S";
      4'd5:    c = "H";
      4'd6:    c = "P";
      4'd7:    c = "=";
      4'd8:    c = "X";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] base_letter(logic [3:0] nib);
    logic [7:0] c;
    case (nib)
      4'd0:    c = "=";
      4'd1:    c = "A";
      4'd2:    c = "C";
      4'd3:    c = "M";
      4'd4:    c = "G";
      4'd5:    c = "R";
      4'd6:    c = "S";
      4'd7:    c = "V";
      4'd8:    c = "T";
      4'd9:    c = "W";
      4'd10:   c = "Y";
      4'd11:   c = "H";
      4'd12:   c = "K";
      4'd13:   c = "D";
      4'd14:   c = "B";
      default: c = "N";
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/arbp_if.sv -----
// ----------------------------------------------------------------------------
// arbp_if
// Valid/ready channels for record bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface arbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

interface arbp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         item_kind;
  logic [7:0]         symbol;
  logic signed [31:0] value;
  logic               record_done;

  modport source (output valid, output item_kind, output symbol, output value,
                  output record_done, input ready);
  modport sink   (input valid, input item_kind, input symbol, input value,
                  input record_done, output ready);
endinterface

// ----- rtl/arbp_step.sv -----
// ----------------------------------------------------------------------------
// arbp_step
// Next-state and result logic for one record byte.
// ----------------------------------------------------------------------------
module arbp_step import arbp_pkg::*; (
  input  arbp_state_t state_i,
  input  logic [7:0]  byte_i,
  input  logic        start_i,
  output arbp_state_t state_o,
  output logic [1:0]  res_cnt_o,
  output res_t        res0_o,
  output res_t        res1_o
);

  arbp_state_t cur;
  arbp_state_t nxt;
  res_t        res [2];
  logic [1:0]  cnt;
  logic [31:0] wa_shift;
  logic [8:0]  name_idx;
  logic [31:0] left_dec;
  logic [31:0] left_dec2;
  logic [15:0] cigar_dec;
  logic        last;

  always_comb begin
    // a record start abandons whatever was in progress
    cur       = start_i ? ST_RESET : state_i;
    nxt       = cur;
    cnt       = 2'd0;
    res[0]    = mk_res(KIND_REF, 8'd0, 32'd0, 1'b0);
    res[1]    = mk_res(KIND_REF, 8'd0, 32'd0, 1'b0);
    wa_shift  = {byte_i, cur.word[31:8]};
    name_idx  = cur.offset - HEADER_BYTES;
    left_dec  = cur.left - 32'd1;
    left_dec2 = cur.left - 32'd2;
    cigar_dec = cur.cigar_cnt - 16'd1;
    last      = (cur.cigar_cnt == 16'd0) && (cur.seq_len == 32'd0);

    if (!cur.failed && cur.section != SEC_TAIL) begin
      case (cur.section)
        SEC_HEADER: begin
          nxt.word = wa_shift;
          if (cur.offset == OFS_REF_ID) begin
            res[cnt[0]] = mk_res(KIND_REF, 8'd0, wa_shift, 1'b0);
            cnt = cnt + 2'd1;
          end else if (cur.offset == OFS_POS) begin
            res[cnt[0]] = mk_res(KIND_POS, 8'd0, wa_shift, 1'b0);
            cnt = cnt + 2'd1;
          end else if (cur.offset == OFS_NAME_LEN) begin
            nxt.name_len = byte_i;
          end else if (cur.offset == OFS_CIGAR_N) begin
            nxt.cigar_cnt = wa_shift[31:16];
          end else if (cur.offset == OFS_SEQ_LEN) begin
            nxt.seq_len = wa_shift;
          end else if (cur.offset == OFS_HDR_LAST) begin
            if (cur.name_len == 8'd0) begin
              res[cnt[0]] = mk_res(KIND_ERR, 8'd0, 32'd0, 1'b1);
              cnt = cnt + 2'd1;
              nxt.failed = 1'b1;
            end else begin
              nxt.section = SEC_NAME;
            end
          end
        end
        SEC_NAME: begin
          // hold each char one byte so the final one can carry record_done
          if ((name_idx + 9'd1) < {1'b0, cur.name_len}) begin
            if (name_idx != 9'd0) begin
              res[cnt[0]] = mk_res(KIND_NAME, cur.word[7:0], 32'd0, 1'b0);
              cnt = cnt + 2'd1;
            end
            nxt.word = {24'd0, byte_i};
          end else begin
            if (name_idx != 9'd0) begin
              res[cnt[0]] = mk_res(KIND_NAME, cur.word[7:0], 32'd0,
                                   (byte_i == 8'd0) && last);
              cnt = cnt + 2'd1;
            end
            if (byte_i != 8'd0) begin
              res[cnt[0]] = mk_res(KIND_ERR, 8'd0, 32'd0, 1'b1);
              cnt = cnt + 2'd1;
              nxt.failed = 1'b1;
            end else if (cur.cigar_cnt != 16'd0) begin
              nxt.section = SEC_CIGAR;
              nxt.phase   = 2'd0;
              nxt.word    = 32'd0;
            end else if (cur.seq_len != 32'd0) begin
              nxt.section = SEC_SEQ;
              nxt.left    = cur.seq_len;
            end else begin
              nxt.section = SEC_TAIL;
            end
          end
        end
        SEC_CIGAR: begin
          nxt.word  = wa_shift;
          nxt.phase = cur.phase + 2'd1;
          if (cur.phase == PHASE_LAST) begin
            if (wa_shift[3:0] > OP_MAX) begin
              res[cnt[0]] = mk_res(KIND_ERR, 8'd0, 32'd0, 1'b1);
              cnt = cnt + 2'd1;
              nxt.failed = 1'b1;
            end else begin
              nxt.cigar_cnt = cigar_dec;
              res[cnt[0]] = mk_res(KIND_OP, op_letter(wa_shift[3:0]),
                                   {4'd0, wa_shift[31:4]},
                                   (cigar_dec == 16'd0) && (cur.seq_len == 32'd0));
              cnt = cnt + 2'd1;
              if (cigar_dec == 16'd0) begin
                if (cur.seq_len != 32'd0) begin
                  nxt.section = SEC_SEQ;
                  nxt.left    = cur.seq_len;
                end else begin
                  nxt.section = SEC_TAIL;
                end
              end
            end
          end
        end
        SEC_SEQ: begin
          res[cnt[0]] = mk_res(KIND_BASE, base_letter(byte_i[7:4]), 32'd0, 1'b0);
          cnt = cnt + 2'd1;
          if (left_dec != 32'd0) begin
            // drop the pad nibble on an odd length
            res[cnt[0]] = mk_res(KIND_BASE, base_letter(byte_i[3:0]), 32'd0, 1'b0);
            cnt = cnt + 2'd1;
            nxt.left = left_dec2;
            if (left_dec2 == 32'd0) begin
              nxt.section = SEC_QUAL;
              nxt.left    = cur.seq_len;
            end
          end else begin
            nxt.section = SEC_QUAL;
            nxt.left    = cur.seq_len;
          end
        end
        SEC_QUAL: begin
          nxt.left = left_dec;
          res[cnt[0]] = mk_res(KIND_QUAL, byte_i, 32'd0, left_dec == 32'd0);
          cnt = cnt + 2'd1;
          if (left_dec == 32'd0) begin
            nxt.section = SEC_TAIL;
          end
        end
        default: begin
        end
      endcase

      if (cur.offset != '1) begin
        nxt.offset = cur.offset + 9'd1;
      end
    end
  end

  assign state_o   = nxt;
  assign res_cnt_o = cnt;
  assign res0_o    = res[0];
  assign res1_o    = res[1];

endmodule

// ----- rtl/arbp_res_fifo.sv -----
// ----------------------------------------------------------------------------
// arbp_res_fifo
// Result queue: takes up to two results a cycle, delivers one per transfer.
// ----------------------------------------------------------------------------
module arbp_res_fifo import arbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_cnt_i,
  input  res_t              push0_i,
  input  res_t              push1_i,
  output logic              space_o,
  arbp_out_if.source        out_o
);

  res_t                 mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wptr_q, wptr_d;
  logic [RES_PTR_W-1:0] rptr_q, rptr_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;
  res_t                 head;

  assign head    = mem_q[rptr_q];
  assign pop     = out_o.valid && out_o.ready;
  // room for the worst case of two results from one byte
  assign space_o = cnt_q <= RES_CNT_W'(RES_DEPTH - 2);

  assign out_o.valid       = cnt_q != '0;
  assign out_o.item_kind   = head.item_kind;
  assign out_o.symbol      = head.symbol;
  assign out_o.value       = head.value;
  assign out_o.record_done = head.record_done;

  always_comb begin
    wptr_d = wptr_q + RES_PTR_W'(push_cnt_i);
    rptr_d = rptr_q + RES_PTR_W'(pop);
    cnt_d  = cnt_q + RES_CNT_W'(push_cnt_i) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wptr_q + RES_PTR_W'(1)] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue count above depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd0 |-> space_o)
    else $error("result pushed without room");

  a_push_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt_i != 2'd3)
    else $error("more than two results from one byte");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == RES_CNT_W'(1) && pop && push_cnt_i == 2'd0) |=> !out_o.valid)
    else $error("queue not empty after last transfer");

endmodule

// ----- rtl/alignment_record_byte_parser_core.sv -----
// ----------------------------------------------------------------------------
// alignment_record_byte_parser_core
// Parses a binary alignment record one byte per transfer into typed results.
// ----------------------------------------------------------------------------
// A byte's results are written into the result queue when the byte transfers.
// Throughput: one byte per cycle while the queue has room; a packed sequence byte
// gives two results, which leave one per transfer through a four-entry queue.
// Input ready drops only when the queue lacks room for two results.
// Reset clears the parse state to the header section and empties the queue.
module alignment_record_byte_parser_core import arbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  arbp_in_if.sink     in_i,
  arbp_out_if.source  out_o
);

  arbp_state_t state_q, state_d;
  arbp_state_t step_state;
  logic [1:0]  step_cnt;
  logic [1:0]  push_cnt;
  res_t        res0, res1;
  logic        space;
  logic        in_fire;

  assign in_i.ready = space;
  assign in_fire    = in_i.valid && in_i.ready;

  arbp_step u_step (
    .state_i   (state_q),
    .byte_i    (in_i.data_byte),
    .start_i   (in_i.record_start),
    .state_o   (step_state),
    .res_cnt_o (step_cnt),
    .res0_o    (res0),
    .res1_o    (res1)
  );

  always_comb begin
    state_d  = in_fire ? step_state : state_q;
    push_cnt = in_fire ? step_cnt : 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  arbp_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (space),
    .out_o      (out_o)
  );

  a_failed_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.failed && !in_i.record_start) |-> push_cnt == 2'd0)
    else $error("result after record error");

  // a packed byte gives two bases; an unterminated name gives its char and an error
  a_pair_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt == 2'd2 |-> ((state_q.section == SEC_SEQ || state_q.section == SEC_NAME) &&
                          !in_i.record_start))
    else $error("two results outside sequence or name section");

  a_err_sets_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((push_cnt != 2'd0 && res0.item_kind == KIND_ERR) ||
     (push_cnt == 2'd2 && res1.item_kind == KIND_ERR)) |=> state_q.failed)
    else $error("error result without failed record");

endmodule

// ----- bench/alignment_record_byte_parser_core_test.sv -----
// ----------------------------------------------------------------------------
// alignment_record_byte_parser_core_test
// Feeds whole alignment records byte by byte, clean and damaged, with random
// gaps on the byte side and random stalls on the result side. Every result
// transfer is checked against a behavioral parser kept in the bench.
// ----------------------------------------------------------------------------
module alignment_record_byte_parser_core_test;
  import arbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_BYTES = 200;
  localparam int unsigned CALM_AFTER   = 160;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned REPORT_MAX   = 10;

  typedef enum int {
    FLAW_NONE,
    FLAW_NO_NUL,
    FLAW_BAD_OP,
    FLAW_CUT,
    FLAW_HUGE
  } flaw_e;

  // Behavioral parser plus the queue of results it predicts
  class record_parse_board;
    res_t        pending_items[$];
    int unsigned errors;
    int unsigned ofs;
    logic [31:0] acc;
    logic [7:0]  name_len;
    logic [15:0] ops_left;
    logic [31:0] seq_len;
    logic [31:0] to_go;
    section_e    sec;
    bit          dead;
    string       op_chars;
    string       base_chars;

    function new();
      op_chars   = "MIDNSHP=X";
      base_chars = "=ACMGRSVTWYHKDBN";
      errors     = 0;
      clear();
    endfunction

    function void clear();
      ofs      = 0;
      acc      = '0;
      name_len = '0;
      ops_left = '0;
      seq_len  = '0;
      to_go    = '0;
      sec      = SEC_HEADER;
      dead     = 1'b0;
    endfunction

    function void queue_item(kind_e k, logic [7:0] s, logic [31:0] v, logic d);
      res_t r;
      r.item_kind   = k;
      r.symbol      = s;
      r.value       = v;
      r.record_done = d;
      pending_items.insert(pending_items.size(), r);
    endfunction

    function void fail_record();
      queue_item(KIND_ERR, 8'd0, 32'd0, 1'b1);
      dead = 1'b1;
    endfunction

    function void after_lengths();
      if (seq_len != 0) begin
        sec   = SEC_SEQ;
        to_go = seq_len;
      end else begin
        sec = SEC_TAIL;
      end
    endfunction

    function int unsigned pending();
      return pending_items.size();
    endfunction

    function void note_byte(logic [7:0] b, logic first);
      int unsigned idx;
      logic        closes;
      logic [3:0]  op;
      if (first) clear();
      if (dead || sec == SEC_TAIL) return;
      case (sec)
        SEC_HEADER: begin
          acc = {b, acc[31:8]};
          if (ofs == OFS_REF_ID) begin
            queue_item(KIND_REF, 8'd0, acc, 1'b0);
          end else if (ofs == OFS_POS) begin
            queue_item(KIND_POS, 8'd0, acc, 1'b0);
          end else if (ofs == OFS_NAME_LEN) begin
            name_len = b;
          end else if (ofs == OFS_CIGAR_N) begin
            ops_left = acc[31:16];
          end else if (ofs == OFS_SEQ_LEN) begin
            seq_len = acc;
          end else if (ofs == OFS_HDR_LAST) begin
            if (name_len == 0) fail_record();
            else sec = SEC_NAME;
          end
        end
        SEC_NAME: begin
          idx = ofs - HEADER_BYTES;
          if (idx + 1 < name_len) begin
            // hold each char one byte so the last one can close the record
            if (idx > 0) queue_item(KIND_NAME, acc[7:0], 32'd0, 1'b0);
            acc = {24'd0, b};
          end else begin
            closes = (ops_left == 0) && (seq_len == 0);
            if (idx > 0) queue_item(KIND_NAME, acc[7:0], 32'd0, (b == 0) && closes);
            if (b != 0) begin
              fail_record();
            end else if (ops_left != 0) begin
              sec = SEC_CIGAR;
              acc = '0;
            end else begin
              after_lengths();
            end
          end
        end
        SEC_CIGAR: begin
          acc = {b, acc[31:8]};
          if (2'(ofs - HEADER_BYTES - name_len) == PHASE_LAST) begin
            op = acc[3:0];
            if (op > OP_MAX) begin
              fail_record();
            end else begin
              ops_left--;
              queue_item(KIND_OP, op_chars[op], {4'd0, acc[31:4]},
                         (ops_left == 0) && (seq_len == 0));
              if (ops_left == 0) after_lengths();
            end
          end
        end
        SEC_SEQ: begin
          queue_item(KIND_BASE, base_chars[b[7:4]], 32'd0, 1'b0);
          to_go--;
          // drop the pad nibble when the length is odd
          if (to_go > 0) begin
            queue_item(KIND_BASE, base_chars[b[3:0]], 32'd0, 1'b0);
            to_go--;
          end
          if (to_go == 0) begin
            sec   = SEC_QUAL;
            to_go = seq_len;
          end
        end
        SEC_QUAL: begin
          to_go--;
          queue_item(KIND_QUAL, b, 32'd0, to_go == 0);
          if (to_go == 0) sec = SEC_TAIL;
        end
        default: ;
      endcase
      if (ofs != 32'hFFFF_FFFF) ofs++;
    endfunction

    function void report(string what, res_t want, res_t got);
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("%s: want kind %0d sym %02h val %08h done %b, got kind %0d sym %02h val %08h done %b",
                 what, want.item_kind, want.symbol, want.value, want.record_done,
                 got.item_kind, got.symbol, got.value, got.record_done);
      end
    endfunction

    function void check_item(kind_e k, logic [7:0] s, logic [31:0] v, logic d);
      res_t got;
      res_t want;
      got.item_kind   = k;
      got.symbol      = s;
      got.value       = v;
      got.record_done = d;
      if (pending_items.size() == 0) begin
        report("unexpected result", got, got);
        return;
      end
      want = pending_items.pop_front();
      if (got.item_kind !== want.item_kind || got.symbol !== want.symbol ||
          got.value !== want.value || got.record_done !== want.record_done) begin
        report("wrong result", want, got);
      end
    endfunction

    function void close_out();
      if (pending_items.size() != 0) begin
        errors += pending_items.size();
        $display("missing results: %0d still outstanding", pending_items.size());
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned bytes_fed;
  int unsigned cycles;

  record_parse_board board;

  arbp_in_if  bytes_if ();
  arbp_out_if items_if ();

  alignment_record_byte_parser_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bytes_if),
    .out_o  (items_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Result side: random stall bursts while allowed
  initial begin
    items_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        items_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      items_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && items_if.valid && items_if.ready) begin
      board.check_item(kind_e'(items_if.item_kind), items_if.symbol, items_if.value,
                       items_if.record_done);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("alignment_record_byte_parser_core: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    bytes_if.valid        <= 1'b1;
    bytes_if.data_byte    <= b;
    bytes_if.record_start <= first;
    do @(posedge clk_i); while (!bytes_if.ready);
    board.note_byte(b, first);
  endtask

  task automatic hold_off();
    bytes_if.valid        <= 1'b0;
    bytes_if.record_start <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk_i);
  endtask

  // Hold the byte side until every predicted result has been taken
  task automatic drain();
    bytes_if.valid        <= 1'b0;
    bytes_if.record_start <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic void put_le(ref logic [7:0] q[$], input logic [31:0] w,
                                 input int n);
    for (int i = 0; i < n; i++) q.insert(q.size(), w[8*i +: 8]);
  endfunction

  task automatic send_record(input logic [31:0] ref_id, input logic [31:0] pos,
                             input int name_len, input int n_ops, input int seq_len,
                             input int tail, input flaw_e flaw, input bit marked);
    logic [7:0]  rec[$];
    logic [31:0] seq_field;
    logic [15:0] ops_field;
    logic [27:0] run;
    logic [3:0]  op;
    int          bad_at;
    int          body_end;
    seq_field = 32'(seq_len);
    ops_field = 16'(n_ops);
    bad_at    = (flaw == FLAW_BAD_OP && n_ops > 0) ? $urandom_range(0, n_ops - 1) : -1;
    // oversized counts: the record is abandoned by the next record start
    if (flaw == FLAW_HUGE) begin
      if ($urandom_range(0, 1) != 0) ops_field = 16'hFF00 | 16'($urandom_range(0, 255));
      else seq_field = 32'h8000_0000 | $urandom;
    end
    put_le(rec, ref_id, 4);
    put_le(rec, pos, 4);
    rec.insert(rec.size(), 8'(name_len));
    put_le(rec, $urandom, 3);
    put_le(rec, {16'd0, ops_field}, 2);
    put_le(rec, $urandom, 2);
    put_le(rec, seq_field, 4);
    for (int i = 0; i < 3; i++) put_le(rec, $urandom, 4);
    if (name_len > 0) begin
      for (int i = 0; i < name_len - 1; i++) begin
        rec.insert(rec.size(), 8'($urandom_range(1, 255)));
      end
      rec.insert(rec.size(), flaw == FLAW_NO_NUL ? 8'($urandom_range(1, 255)) : 8'd0);
    end
    for (int i = 0; i < n_ops; i++) begin
      case ($urandom_range(0, 3))
        0:       run = '0;
        1:       run = '1;
        default: run = 28'($urandom);
      endcase
      // nine ops walk every code in order
      if (i == bad_at) op = 4'($urandom_range(9, 15));
      else if (n_ops == 9) op = 4'(i);
      else op = 4'($urandom_range(0, 8));
      put_le(rec, {run, op}, 4);
    end
    for (int i = 0; i < (seq_len + 1) / 2; i++) rec.insert(rec.size(), 8'($urandom));
    for (int i = 0; i < seq_len; i++) rec.insert(rec.size(), 8'($urandom));
    body_end = rec.size();
    for (int i = 0; i < tail; i++) rec.insert(rec.size(), 8'($urandom));
    if (flaw == FLAW_CUT) begin
      body_end = $urandom_range(1, body_end - 1);
      while (rec.size() > body_end) void'(rec.pop_back());
    end
    bytes_fed += body_end;
    for (int i = 0; i < rec.size(); i++) begin
      if (gaps_on && $urandom_range(0, 7) == 0) hold_off();
      send_byte(rec[i], marked && i == 0);
    end
  endtask

  initial begin
    int    pick;
    int    nlen;
    bit    paused;
    flaw_e flaw;
    board                 = new();
    rst_ni                = 1'b0;
    bytes_if.valid        = 1'b0;
    bytes_if.data_byte    = 8'd0;
    bytes_if.record_start = 1'b0;
    gaps_on               = 1'b1;
    stalls_on             = 1'b1;
    bytes_fed             = 0;
    paused                = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first record after reset carries no start mark
    send_record(32'hFFFF_FFFF, 32'h7FFF_FFFF, 3, 1, 2, 0, FLAW_NONE, 1'b0);
    send_record(32'h8000_0000, 32'h0000_0000, 2, 9, 5, 2, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 0, 2, 4, 3, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 4, 1, 2, 2, FLAW_NO_NUL, 1'b1);
    send_record($urandom, $urandom, 1, 0, 0, 0, FLAW_NO_NUL, 1'b1);
    send_record($urandom, $urandom, 2, 3, 4, 2, FLAW_BAD_OP, 1'b1);
    send_record(32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 0, 2, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 2, 0, 0, 1, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 1, 0, 32, 0, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 255, 0, 1, 0, FLAW_NONE, 1'b1);
    send_record($urandom, $urandom, 3, 2, 6, 0, FLAW_HUGE, 1'b1);
    send_record($urandom, $urandom, 3, 2, 6, 0, FLAW_CUT, 1'b1);
    drain();

    bytes_fed = 0;
    while (bytes_fed < RANDOM_BYTES) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) flaw = FLAW_NONE;
      else if (pick < 15) flaw = FLAW_NO_NUL;
      else if (pick < 16) flaw = FLAW_BAD_OP;
      else if (pick < 18) flaw = FLAW_CUT;
      else flaw = FLAW_HUGE;
      nlen = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 10);
      gaps_on   = bytes_fed < CALM_AFTER && $urandom_range(0, 3) != 0;
      stalls_on = bytes_fed < CALM_AFTER && $urandom_range(0, 3) != 0;
      send_record($urandom, $urandom, nlen, $urandom_range(0, 4), $urandom_range(0, 12),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, flaw, 1'b1);
      if (!paused && bytes_fed > RANDOM_BYTES / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    board.close_out();
    if (board.errors == 0) begin
      $display("alignment_record_byte_parser_core: match");
    end else begin
      $display("alignment_record_byte_parser_core: mismatch");
    end
    $finish;
  end

endmodule
